// File: src/arp_pkg.sv
package arp_pkg;

    // sizing
    localparam int NOTE_SLOTS     = 32;
    localparam int MAX_OCTAVES    = 4;
    localparam int TICK_PERIOD_MS = 1;

    localparam int SEMITONES_PER_OCTAVE = 12;
    localparam int MIN_PERIOD_MS        = 10;
    localparam int SPEED_FRAC_W         = 8;

    localparam int SLOT_W     = 5;
    localparam int NOTE_W     = 8;
    localparam int MASK_W     = 32;
    localparam int TICK_W     = 32;
    localparam int RAND_W     = 16;
    localparam int CFG_W      = 16;

    localparam int SLOT_IDX_W = (NOTE_SLOTS > 1) ? $clog2(NOTE_SLOTS) : 1;
    localparam int COUNT_W    = $clog2(NOTE_SLOTS + 1);
    localparam int OCT_W      = $clog2(MAX_OCTAVES + 1);
    localparam int TOTAL_W    = $clog2(NOTE_SLOTS * MAX_OCTAVES + 1);
    localparam int STEP_W     = TOTAL_W + 1;

    localparam logic [MASK_W-1:0] SLOT_MASK =
        (NOTE_SLOTS >= MASK_W) ? {MASK_W{1'b1}} : MASK_W'((64'd1 << NOTE_SLOTS) - 64'd1);

    // shared divider
    localparam int DIV_W     = CFG_W + SPEED_FRAC_W;
    localparam int DIVR_W    = CFG_W;
    localparam int DIV_CNT_W = $clog2(DIV_W + 1);

    localparam int ELAPSED_W = TICK_W + $clog2(TICK_PERIOD_MS + 1);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    // configuration port
    localparam int REG_COUNT = 6;
    localparam int ADDR_W    = $clog2(REG_COUNT * 4);
    localparam int DATA_W    = 32;

    localparam logic [ADDR_W-3:0] REG_ENABLE = 3'd0;
    localparam logic [ADDR_W-3:0] REG_MODE   = 3'd1;
    localparam logic [ADDR_W-3:0] REG_SPAN   = 3'd2;
    localparam logic [ADDR_W-3:0] REG_BASE   = 3'd3;
    localparam logic [ADDR_W-3:0] REG_SCALE  = 3'd4;
    localparam logic [ADDR_W-3:0] REG_CHANCE = 3'd5;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    localparam logic [2:0] MODE_UP       = 3'd0;
    localparam logic [2:0] MODE_DOWN     = 3'd1;
    localparam logic [2:0] MODE_PINGPONG = 3'd2;
    localparam logic [2:0] MODE_RANDOM   = 3'd3;
    localparam logic [2:0] MODE_UPDOWN   = 3'd4;

    typedef struct packed {
        logic                 op;
        logic [SLOT_W-1:0]    slot;
        logic [NOTE_W-1:0]    note_value;
        logic [MASK_W-1:0]    held_mask;
        logic [TICK_W-1:0]    now_ticks;
        logic [RAND_W-1:0]    random_index;
        logic [RAND_W-1:0]    random_chance;
    } in_item_t;

    typedef struct packed {
        logic [NOTE_W-1:0] note_out;
        logic              sounding;
    } out_item_t;

    typedef struct packed {
        logic             enable;
        logic [2:0]       pattern_mode;
        logic [2:0]       octave_span;
        logic [CFG_W-1:0] base_period_ms;
        logic [CFG_W-1:0] speed_scale;
        logic [CFG_W-1:0] play_chance;
    } cfg_t;

    typedef struct packed {
        logic                 is_tick;
        logic [SLOT_W-1:0]    slot;
        logic [NOTE_W-1:0]    note_value;
        logic [MASK_W-1:0]    held_mask;
        logic [COUNT_W-1:0]   note_count;
        logic [TICK_W-1:0]    now_ticks;
        logic [RAND_W-1:0]    random_index;
        logic [RAND_W-1:0]    random_chance;
    } q_entry_t;

    typedef struct packed {
        logic                 start;
        logic [DIV_W-1:0]     dividend;
        logic [DIVR_W-1:0]    divisor;
        logic [DIV_CNT_W-1:0] steps;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [DIV_W-1:0]  quotient;
        logic [DIVR_W-1:0] remainder;
    } div_rsp_t;

endpackage

// File: src/arp_front.sv
module arp_front (
    input  logic               s_valid,
    output logic               s_ready,
    input  arp_pkg::in_item_t  s_data,
    output logic               push_valid,
    input  logic               push_ready,
    output arp_pkg::q_entry_t  push_data
);
    import arp_pkg::*;

    localparam int NIBBLES = MASK_W / 4;

    function automatic logic [2:0] pop4(input logic [3:0] v);
        return {2'b0, v[0]} + {2'b0, v[1]} + {2'b0, v[2]} + {2'b0, v[3]};
    endfunction

    logic [MASK_W-1:0]  held;
    logic [COUNT_W-1:0] count;

    assign held = s_data.held_mask & SLOT_MASK;

    always_comb begin
        count = '0;
        for (int k = 0; k < NIBBLES; k++) begin
            count = count + COUNT_W'(pop4(held[4*k +: 4]));
        end
    end

    assign s_ready    = push_ready;
    assign push_valid = s_valid;

    always_comb begin
        push_data               = '0;
        push_data.is_tick       = (s_data.op == OP_TICK);
        push_data.slot          = s_data.slot;
        push_data.note_value    = s_data.note_value;
        push_data.held_mask     = held;
        push_data.note_count    = count;
        push_data.now_ticks     = s_data.now_ticks;
        push_data.random_index  = s_data.random_index;
        push_data.random_chance = s_data.random_chance;
    end

endmodule

// File: src/arp_fifo.sv
module arp_fifo (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  arp_pkg::q_entry_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output arp_pkg::q_entry_t  out_data
);
    import arp_pkg::*;

    q_entry_t          mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;
    logic              push;
    logic              pop;

    assign in_ready  = (count_reg != (QPTR_W + 1)'(QUEUE_DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_data  = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    function automatic logic [QPTR_W-1:0] bump(input logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= bump(wr_ptr_reg);
            end
            if (pop) begin
                rd_ptr_reg <= bump(rd_ptr_reg);
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

// File: src/arp_div.sv
module arp_div (
    input  logic               aclk,
    input  logic               aresetn,
    input  arp_pkg::div_req_t  req,
    output arp_pkg::div_rsp_t  rsp
);
    import arp_pkg::*;

    logic [DIVR_W-1:0]    rem_reg;
    logic [DIV_W-1:0]     quo_reg;
    logic [DIVR_W-1:0]    dvs_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;

    logic [DIVR_W:0] shifted;
    logic [DIVR_W:0] trial;
    logic            fits;

    // restoring division, one quotient bit per cycle
    assign shifted = {rem_reg, quo_reg[DIV_W-1]};
    assign trial   = shifted - {1'b0, dvs_reg};
    assign fits    = (shifted >= {1'b0, dvs_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= req.steps;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DIV_CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            rem_reg <= '0;
            quo_reg <= req.dividend;
            dvs_reg <= req.divisor;
        end else if (busy_reg) begin
            rem_reg <= fits ? trial[DIVR_W-1:0] : shifted[DIVR_W-1:0];
            quo_reg <= {quo_reg[DIV_W-2:0], fits};
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

// File: src/arp_back.sv
module arp_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  arp_pkg::cfg_t      cfg,
    input  logic               q_valid,
    output logic               q_ready,
    input  arp_pkg::q_entry_t  q_data,
    output arp_pkg::div_req_t  div_req,
    input  arp_pkg::div_rsp_t  div_rsp,
    output logic               m_valid,
    input  logic               m_ready,
    output arp_pkg::out_item_t m_data
);
    import arp_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PERIOD,
        S_RAND,
        S_CHECK,
        S_LOC,
        S_SCAN,
        S_EMIT
    } state_t;

    state_t                    state_reg;
    q_entry_t                  ent_reg;
    logic [NOTE_W-1:0]         table_reg [NOTE_SLOTS];
    logic signed [STEP_W-1:0]  step_reg;
    logic                      down_reg;
    logic [TICK_W-1:0]         last_reg;
    logic                      active_reg;
    logic [TOTAL_W-1:0]        total_reg;
    logic [OCT_W-1:0]          oct_reg;
    logic [COUNT_W-1:0]        rank_reg;
    logic [COUNT_W-1:0]        seen_reg;
    logic [SLOT_IDX_W-1:0]     scan_reg;
    logic [NOTE_W-1:0]         res_note_reg;
    logic                      res_snd_reg;
    logic                      out_valid_reg;
    out_item_t                 out_data_reg;

    logic [OCT_W-1:0]          oct_span;
    logic [TOTAL_W-1:0]        total_calc;
    logic [CFG_W-1:0]          scale_nz;
    logic [DIV_W-1:0]          period;
    logic [TICK_W-1:0]         since_last;
    logic [ELAPSED_W-1:0]      elapsed_ms;
    logic                      step_hit;
    logic signed [STEP_W-1:0]  tot_s;
    logic signed [STEP_W-1:0]  last_s;
    logic signed [STEP_W-1:0]  inc_s;
    logic signed [STEP_W-1:0]  dec_s;
    logic signed [STEP_W-1:0]  step_moved;
    logic                      down_moved;
    logic signed [STEP_W-1:0]  step_clamp;
    logic [NOTE_W-1:0]         pitch;
    logic                      start_tick;

    assign q_ready = (state_reg == S_IDLE);
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    always_comb begin
        if (cfg.octave_span == 3'd0) begin
            oct_span = OCT_W'(1);
        end else if (32'(cfg.octave_span) > MAX_OCTAVES) begin
            oct_span = OCT_W'(MAX_OCTAVES);
        end else begin
            oct_span = OCT_W'(cfg.octave_span);
        end
    end

    assign total_calc = TOTAL_W'(q_data.note_count) * TOTAL_W'(oct_span);
    assign scale_nz   = (cfg.speed_scale == '0) ? CFG_W'(1) : cfg.speed_scale;
    assign period     = (div_rsp.quotient < DIV_W'(MIN_PERIOD_MS)) ?
                        DIV_W'(MIN_PERIOD_MS) : div_rsp.quotient;
    // tick difference wraps at the counter width before scaling
    assign since_last = ent_reg.now_ticks - last_reg;
    assign elapsed_ms = ELAPSED_W'(since_last) * ELAPSED_W'(TICK_PERIOD_MS);
    assign step_hit   = (elapsed_ms >= ELAPSED_W'(period));

    assign tot_s  = $signed({1'b0, total_reg});
    assign last_s = tot_s - STEP_W'(1);
    assign inc_s  = step_reg + STEP_W'(1);
    assign dec_s  = step_reg - STEP_W'(1);

    // step movement for the walking modes; random mode goes through the divider
    always_comb begin
        step_moved = step_reg;
        down_moved = down_reg;
        unique case (cfg.pattern_mode)
            MODE_UP: begin
                step_moved = (inc_s >= tot_s) ? '0 : inc_s;
            end
            MODE_DOWN: begin
                step_moved = (dec_s < 0) ? last_s : dec_s;
            end
            MODE_PINGPONG: begin
                if (down_reg) begin
                    step_moved = dec_s;
                    if (dec_s <= 0) begin
                        step_moved = '0;
                        down_moved = 1'b0;
                    end
                end else begin
                    step_moved = inc_s;
                    if (inc_s >= last_s) begin
                        step_moved = last_s;
                        down_moved = 1'b1;
                    end
                end
            end
            MODE_UPDOWN: begin
                if (down_reg) begin
                    step_moved = dec_s;
                    if (dec_s < 0) begin
                        step_moved = '0;
                        down_moved = 1'b0;
                    end
                end else begin
                    step_moved = inc_s;
                    if (inc_s >= tot_s) begin
                        step_moved = last_s;
                        down_moved = 1'b1;
                    end
                end
            end
            default: begin
                step_moved = step_reg;
                down_moved = down_reg;
            end
        endcase
    end

    always_comb begin
        if (step_reg >= tot_s) begin
            step_clamp = last_s;
        end else if (step_reg < 0) begin
            step_clamp = '0;
        end else begin
            step_clamp = step_reg;
        end
    end

    assign pitch = table_reg[scan_reg] + NOTE_W'(SEMITONES_PER_OCTAVE * oct_reg);

    assign start_tick = q_valid && q_data.is_tick && cfg.enable && (q_data.note_count != '0);

    always_comb begin
        div_req = '0;
        unique case (state_reg)
            S_IDLE: begin
                div_req.start    = start_tick;
                div_req.dividend = {cfg.base_period_ms, SPEED_FRAC_W'(0)};
                div_req.divisor  = scale_nz;
                div_req.steps    = DIV_CNT_W'(DIV_W);
            end
            S_PERIOD: begin
                div_req.start    = div_rsp.done && step_hit &&
                                   (cfg.pattern_mode == MODE_RANDOM);
                div_req.dividend = {ent_reg.random_index, (DIV_W - RAND_W)'(0)};
                div_req.divisor  = DIVR_W'(total_reg);
                div_req.steps    = DIV_CNT_W'(RAND_W);
            end
            S_CHECK: begin
                div_req.start    = active_reg;
                div_req.dividend = {step_clamp[TOTAL_W-1:0], (DIV_W - TOTAL_W)'(0)};
                div_req.divisor  = DIVR_W'(ent_reg.note_count);
                div_req.steps    = DIV_CNT_W'(TOTAL_W);
            end
            default: begin
                div_req = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            step_reg      <= '1;            // minus one
            down_reg      <= 1'b0;
            last_reg      <= '0;
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < NOTE_SLOTS; k++) begin
                table_reg[k] <= '0;
            end
        end else begin
            // S_EMIT drives the output register itself
            if (m_ready && (state_reg != S_EMIT)) begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (q_valid) begin
                        ent_reg <= q_data;
                        if (!q_data.is_tick) begin
                            if (32'(q_data.slot) < NOTE_SLOTS) begin
                                table_reg[q_data.slot[SLOT_IDX_W-1:0]] <= q_data.note_value;
                            end
                        end else if (!cfg.enable) begin
                            res_note_reg <= '0;
                            res_snd_reg  <= 1'b0;
                            state_reg    <= S_EMIT;
                        end else if (q_data.note_count == '0) begin
                            step_reg     <= '1;
                            active_reg   <= 1'b0;
                            res_note_reg <= '0;
                            res_snd_reg  <= 1'b0;
                            state_reg    <= S_EMIT;
                        end else begin
                            total_reg <= total_calc;
                            state_reg <= S_PERIOD;
                        end
                    end
                end
                S_PERIOD: begin
                    if (div_rsp.done) begin
                        if (step_hit) begin
                            last_reg   <= ent_reg.now_ticks;
                            active_reg <= (ent_reg.random_chance <= cfg.play_chance);
                            if (cfg.pattern_mode == MODE_RANDOM) begin
                                state_reg <= S_RAND;
                            end else begin
                                step_reg  <= step_moved;
                                down_reg  <= down_moved;
                                state_reg <= S_CHECK;
                            end
                        end else begin
                            state_reg <= S_CHECK;
                        end
                    end
                end
                S_RAND: begin
                    if (div_rsp.done) begin
                        step_reg  <= $signed({1'b0, div_rsp.remainder[TOTAL_W-1:0]});
                        state_reg <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (!active_reg) begin
                        res_note_reg <= '0;
                        res_snd_reg  <= 1'b0;
                        state_reg    <= S_EMIT;
                    end else begin
                        step_reg  <= step_clamp;
                        state_reg <= S_LOC;
                    end
                end
                S_LOC: begin
                    // quotient picks the octave, remainder the rank among held slots
                    if (div_rsp.done) begin
                        oct_reg   <= div_rsp.quotient[OCT_W-1:0];
                        rank_reg  <= div_rsp.remainder[COUNT_W-1:0];
                        seen_reg  <= '0;
                        scan_reg  <= '0;
                        state_reg <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (ent_reg.held_mask[scan_reg] && (seen_reg == rank_reg)) begin
                        res_note_reg <= pitch;
                        res_snd_reg  <= 1'b1;
                        state_reg    <= S_EMIT;
                    end else begin
                        if (ent_reg.held_mask[scan_reg]) begin
                            seen_reg <= seen_reg + 1'b1;
                        end
                        scan_reg <= scan_reg + 1'b1;
                    end
                end
                S_EMIT: begin
                    if (!out_valid_reg || m_ready) begin
                        out_valid_reg         <= 1'b1;
                        out_data_reg.note_out <= res_note_reg;
                        out_data_reg.sounding <= res_snd_reg;
                        state_reg             <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// File: src/note_arpeggiator.sv
// Arpeggiator over held scale notes. Write items (op 0) load a note into one of 32
// slots; tick items (op 1) give one result each: the current arpeggio note with
// sounding set, or 0 when disabled, nothing is held, or the step did not play.
// Items pass through a two-entry queue, so up to two items are taken in while the
// back end works or a result waits at the output register. A write item retires in
// the idle state. A tick that is disabled or has nothing held goes straight to the
// emit state; any other tick uses a shared radix-2 divider for the step period
// (24 steps), in random mode on a step for the index modulo (16 steps), and, if the
// step plays, for the octave/rank split (8 steps), after which the held slots are
// scanned one per cycle until the selected one is found. Configuration registers
// sit on the APB port at byte offsets 0x00 enable, 0x04 pattern_mode, 0x08
// octave_span, 0x0C base_period_ms, 0x10 speed_scale, 0x14 play_chance.
module note_arpeggiator (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  arp_pkg::in_item_t            s_data,
    output logic                         m_valid,
    input  logic                         m_ready,
    output arp_pkg::out_item_t           m_data,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [arp_pkg::ADDR_W-1:0]   paddr,
    input  logic [arp_pkg::DATA_W-1:0]   pwdata,
    output logic [arp_pkg::DATA_W-1:0]   prdata,
    output logic                         pready
);
    import arp_pkg::*;

    cfg_t      cfg_reg;
    logic      cfg_wr;

    logic      push_valid;
    logic      push_ready;
    q_entry_t  push_data;
    logic      q_valid;
    logic      q_ready;
    q_entry_t  q_data;
    div_req_t  div_req;
    div_rsp_t  div_rsp;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.enable         <= 1'b0;
            cfg_reg.pattern_mode   <= MODE_UP;
            cfg_reg.octave_span    <= 3'd1;
            cfg_reg.base_period_ms <= CFG_W'(125);
            cfg_reg.speed_scale    <= CFG_W'(256);
            cfg_reg.play_chance    <= '1;
        end else if (cfg_wr) begin
            unique case (paddr[ADDR_W-1:2])
                REG_ENABLE: cfg_reg.enable         <= pwdata[0];
                REG_MODE:   cfg_reg.pattern_mode   <= pwdata[2:0];
                REG_SPAN:   cfg_reg.octave_span    <= pwdata[2:0];
                REG_BASE:   cfg_reg.base_period_ms <= pwdata[CFG_W-1:0];
                REG_SCALE:  cfg_reg.speed_scale    <= pwdata[CFG_W-1:0];
                REG_CHANCE: cfg_reg.play_chance    <= pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[ADDR_W-1:2])
            REG_ENABLE: prdata = DATA_W'(cfg_reg.enable);
            REG_MODE:   prdata = DATA_W'(cfg_reg.pattern_mode);
            REG_SPAN:   prdata = DATA_W'(cfg_reg.octave_span);
            REG_BASE:   prdata = DATA_W'(cfg_reg.base_period_ms);
            REG_SCALE:  prdata = DATA_W'(cfg_reg.speed_scale);
            REG_CHANCE: prdata = DATA_W'(cfg_reg.play_chance);
            default:    prdata = '0;
        endcase
    end

    arp_front u_front (
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    arp_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (push_valid),
        .in_ready  (push_ready),
        .in_data   (push_data),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_data  (q_data)
    );

    arp_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    arp_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_data  (q_data),
        .div_req (div_req),
        .div_rsp (div_rsp),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import arp_pkg::*;

    localparam int DRAIN_CYCLES   = 150;
    localparam int HOLD_CYCLES    = 400;
    localparam int HOLD_AFTER     = 150;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int RANDOM_PHASES  = 15;
    localparam int PHASE_ITEMS    = 72;
    localparam int MAX_REPORTS    = 40;

    localparam logic [2:0] MODE_RESERVED = 3'd7;

    logic                aclk;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    in_item_t            s_data  = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    out_item_t           m_data;
    logic                psel    = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite  = 1'b0;
    logic [ADDR_W-1:0]   paddr   = '0;
    logic [DATA_W-1:0]   pwdata  = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    note_arpeggiator dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // arpeggiator state as the block should hold it
    cfg_t        arp_cfg;
    logic [7:0]  slot_notes [NOTE_SLOTS];
    int          step_pos;
    logic        descending;
    logic [31:0] last_step_at;
    logic        playing;

    in_item_t    pending_items [$];
    out_item_t   notes_due_q [$];

    logic        s_took = 1'b0;
    logic        m_took = 1'b0;
    logic        calm = 1'b1;
    int          tx_gap = 0;
    int          rx_gap = 0;
    int          hold_left = 0;
    logic        held_once = 1'b0;
    int          results_seen = 0;
    int          errors = 0;
    int          stall_cycles = 0;
    logic [31:0] tick_clock;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic logic [31:0] step_period(cfg_t c);
        logic [31:0] divisor;
        logic [31:0] per;
        divisor = (c.speed_scale == '0) ? 32'd1 : 32'(c.speed_scale);
        per = (32'(c.base_period_ms) << SPEED_FRAC_W) / divisor;
        return (per < MIN_PERIOD_MS) ? 32'(MIN_PERIOD_MS) : per;
    endfunction

    function automatic out_item_t predict_tick(in_item_t it);
        out_item_t   res;
        logic [7:0]  held [NOTE_SLOTS];
        int          cnt;
        int          octs;
        int          total;
        logic [31:0] elapsed;
        res = '0;
        cnt = 0;
        if (!arp_cfg.enable)
            return res;
        for (int i = 0; i < NOTE_SLOTS; i++) begin
            if (it.held_mask[i]) begin
                held[cnt] = slot_notes[i];
                cnt++;
            end
        end
        if (cnt == 0) begin
            step_pos = -1;
            playing = 1'b0;
            return res;
        end
        octs = int'(arp_cfg.octave_span);
        if (octs < 1) octs = 1;
        if (octs > MAX_OCTAVES) octs = MAX_OCTAVES;
        total = cnt * octs;

        elapsed = it.now_ticks - last_step_at;
        if (64'(elapsed) * TICK_PERIOD_MS >= 64'(step_period(arp_cfg))) begin
            last_step_at = it.now_ticks;
            case (arp_cfg.pattern_mode)
                MODE_UP: begin
                    step_pos++;
                    if (step_pos >= total) step_pos = 0;
                end
                MODE_DOWN: begin
                    step_pos--;
                    if (step_pos < 0) step_pos = total - 1;
                end
                MODE_PINGPONG: begin
                    if (descending) begin
                        step_pos--;
                        if (step_pos <= 0) begin
                            step_pos = 0;
                            descending = 1'b0;
                        end
                    end else begin
                        step_pos++;
                        if (step_pos >= total - 1) begin
                            step_pos = total - 1;
                            descending = 1'b1;
                        end
                    end
                end
                MODE_RANDOM: step_pos = int'(it.random_index) % total;
                MODE_UPDOWN: begin
                    // ends are played twice: turn only after passing them
                    if (descending) begin
                        step_pos--;
                        if (step_pos < 0) begin
                            step_pos = 0;
                            descending = 1'b0;
                        end
                    end else begin
                        step_pos++;
                        if (step_pos >= total) begin
                            step_pos = total - 1;
                            descending = 1'b1;
                        end
                    end
                end
                default: ;
            endcase
            playing = (it.random_chance <= arp_cfg.play_chance);
        end
        if (!playing)
            return res;

        // index may be stale after the held set shrank
        if (step_pos >= total) step_pos = total - 1;
        if (step_pos < 0) step_pos = 0;
        res.note_out = NOTE_W'(int'(held[step_pos % cnt]) +
                               SEMITONES_PER_OCTAVE * (step_pos / cnt));
        res.sounding = 1'b1;
        return res;
    endfunction

    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic in_item_t write_item(logic [SLOT_W-1:0] slot, logic [NOTE_W-1:0] nv);
        in_item_t it;
        it = '0;
        it.op = OP_WRITE;
        it.slot = slot;
        it.note_value = nv;
        return it;
    endfunction

    function automatic in_item_t tick_item(logic [31:0] mask, logic [31:0] now,
                                           logic [15:0] ridx, logic [15:0] rch);
        in_item_t it;
        it = '0;
        it.op = OP_TICK;
        it.held_mask = mask;
        it.now_ticks = now;
        it.random_index = ridx;
        it.random_chance = rch;
        return it;
    endfunction

    function automatic logic [31:0] rand_chord();
        logic [31:0] m;
        m = '0;
        repeat ($urandom_range(1, 6)) m[$urandom_range(0, NOTE_SLOTS - 1)] = 1'b1;
        return m;
    endfunction

    task automatic cfg_write(logic [ADDR_W-3:0] idx, logic [DATA_W-1:0] val);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        case (idx)
            REG_ENABLE: arp_cfg.enable         = val[0];
            REG_MODE:   arp_cfg.pattern_mode   = val[2:0];
            REG_SPAN:   arp_cfg.octave_span    = val[2:0];
            REG_BASE:   arp_cfg.base_period_ms = val[15:0];
            REG_SCALE:  arp_cfg.speed_scale    = val[15:0];
            REG_CHANCE: arp_cfg.play_chance    = val[15:0];
            default: ;
        endcase
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apply_cfg(cfg_t c);
        cfg_write(REG_ENABLE, 32'(c.enable));
        cfg_write(REG_MODE,   32'(c.pattern_mode));
        cfg_write(REG_SPAN,   32'(c.octave_span));
        cfg_write(REG_BASE,   32'(c.base_period_ms));
        cfg_write(REG_SCALE,  32'(c.speed_scale));
        cfg_write(REG_CHANCE, 32'(c.play_chance));
    endtask

    // write items give no result, so pause after the last note before touching registers
    task automatic wait_idle();
        while (pending_items.size() != 0 || s_valid || notes_due_q.size() != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic queue_random(int count, logic [31:0] per);
        in_item_t    it;
        logic [31:0] chord;
        logic [31:0] mask;
        logic [15:0] rch;
        int          r;
        chord = rand_chord();
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(0, 99);
            if (r < 25) begin
                it = write_item(SLOT_W'($urandom), NOTE_W'($urandom));
                it.held_mask = $urandom;
                it.now_ticks = $urandom;
                it.random_index = RAND_W'($urandom);
                it.random_chance = RAND_W'($urandom);
            end else begin
                if ($urandom_range(0, 19) == 0)
                    chord = rand_chord();
                r = $urandom_range(0, 99);
                if (r < 80)      mask = chord;
                else if (r < 88) mask = $urandom;
                else if (r < 94) mask = '0;
                else             mask = '1;
                r = $urandom_range(0, 99);
                if (r < 90)      tick_clock = tick_clock + $urandom_range(0, 2 * per);
                else if (r >= 95) tick_clock = $urandom;
                r = $urandom_range(0, 19);
                if (r == 0)      rch = '0;
                else if (r == 1) rch = '1;
                else             rch = RAND_W'($urandom);
                it = tick_item(mask, tick_clock, RAND_W'($urandom), rch);
                it.slot = SLOT_W'($urandom);
                it.note_value = NOTE_W'($urandom);
            end
            pending_items.push_back(it);
        end
    endtask

    initial begin : stimulus
        cfg_t        c;
        logic [31:0] chord;
        arp_cfg = '{1'b0, MODE_UP, 3'd1, 16'd125, 16'd256, 16'hFFFF};
        for (int i = 0; i < NOTE_SLOTS; i++) slot_notes[i] = '0;
        step_pos = -1;
        descending = 1'b0;
        last_step_at = '0;
        playing = 1'b0;

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        calm = 1'b0;

        // still disabled out of reset
        pending_items.push_back(tick_item('1, 32'd50, 16'hFFFF, 16'h0000));
        wait_idle();

        c = '{1'b1, MODE_UP, 3'd2, 16'd0, 16'd256, 16'hFFFF};
        apply_cfg(c);
        chord = 32'h8002_0021;
        pending_items.push_back(write_item(5'd0, 8'd0));
        pending_items.push_back(write_item(5'd31, 8'd255));
        pending_items.push_back(write_item(5'd5, 8'd60));
        pending_items.push_back(write_item(5'd17, 8'd250));
        pending_items.push_back(write_item(5'd9, 8'd127));
        pending_items.push_back(tick_item('0, 32'd100, 16'h0000, 16'h0000));
        pending_items.push_back(tick_item('1, 32'd110, 16'hFFFF, 16'hFFFF));
        pending_items.push_back(tick_item(chord, 32'd115, 16'h0000, 16'h0000));
        // full walk over two octaves, top notes wrap past 255
        for (int t = 120; t < 200; t += 10)
            pending_items.push_back(tick_item(chord, 32'(t), 16'h0000, 16'hFFFF));
        pending_items.push_back(tick_item(chord, 32'hFFFF_FFF0, 16'hFFFF, 16'h0000));
        pending_items.push_back(tick_item(chord, 32'h0000_0005, 16'h0000, 16'h0000));
        // held set shrinks to one note: index is clamped with and without a step
        pending_items.push_back(tick_item(32'h8000_0000, 32'h0000_0020, 16'h0000, 16'h0000));
        pending_items.push_back(tick_item(32'h8000_0000, 32'h0000_0021, 16'h0000, 16'h0000));
        pending_items.push_back(tick_item('0, 32'h0000_0030, 16'h0000, 16'h0000));
        wait_idle();
        tick_clock = 32'h0000_0040;

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            case (ph)
                0: c = '{1'b1, MODE_DOWN, 3'd0, 16'hFFFF, 16'hFFFF, 16'h0000};
                1: c = '{1'b1, MODE_PINGPONG, 3'd7, 16'd0, 16'd0, 16'hFFFF};
                2: c = '{1'b1, MODE_RANDOM, 3'd4, 16'd1000, 16'd1, 16'd32768};
                3: c = '{1'b1, MODE_UPDOWN, 3'd3, 16'd125, 16'd256, 16'hFFFF};
                4: c = '{1'b1, MODE_RESERVED, 3'd1, 16'd40, 16'd512, 16'd40000};
                5: c = '{1'b0, MODE_UP, 3'd2, 16'd20, 16'd256, 16'hFFFF};
                default: begin
                    c.enable = ($urandom_range(0, 9) != 0);
                    c.pattern_mode = ($urandom_range(0, 5) == 0) ? 3'($urandom_range(5, 7))
                                                                 : 3'($urandom_range(0, 4));
                    c.octave_span = 3'($urandom_range(0, 7));
                    c.base_period_ms = ($urandom_range(0, 9) < 7) ?
                                       16'($urandom_range(0, 300)) :
                                       16'($urandom_range(0, 65535));
                    c.speed_scale = ($urandom_range(0, 9) < 8) ?
                                    16'($urandom_range(64, 1024)) :
                                    16'($urandom_range(0, 65535));
                    c.play_chance = ($urandom_range(0, 6) == 0) ? 16'hFFFF
                                                                : 16'($urandom);
                end
            endcase
            calm = ($urandom_range(0, 3) == 0);
            apply_cfg(c);
            queue_random(PHASE_ITEMS, step_period(c));
            wait_idle();
        end

        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // sender
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            tx_gap <= 0;
        end else if (s_valid && !s_took) begin
            // item still waiting
        end else if (tx_gap > 0) begin
            s_valid <= 1'b0;
            tx_gap <= tx_gap - 1;
        end else if (pending_items.size() != 0) begin
            s_data <= pending_items.pop_front();
            s_valid <= 1'b1;
            tx_gap <= pick_gap();
        end else begin
            s_valid <= 1'b0;
        end
    end

    // receiver, with one long hold-off so the input side backs up
    always @(negedge aclk) begin : receiver
        int g;
        g = 0;
        if (!aresetn) begin
            m_ready <= 1'b0;
            rx_gap <= 0;
        end else if (hold_left > 0) begin
            m_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (!held_once && results_seen >= HOLD_AFTER) begin
            m_ready <= 1'b0;
            hold_left <= HOLD_CYCLES;
            held_once <= 1'b1;
        end else if (rx_gap > 0) begin
            m_ready <= 1'b0;
            rx_gap <= rx_gap - 1;
        end else begin
            if (m_took || $urandom_range(0, 15) == 0)
                g = pick_gap();
            m_ready <= (g == 0);
            rx_gap <= (g > 0) ? g - 1 : 0;
        end
    end

    // both channels: predict on input, check on output
    always @(posedge aclk) begin : monitor
        out_item_t want;
        s_took <= s_valid && s_ready;
        m_took <= m_valid && m_ready;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (notes_due_q.size() == 0) begin
                    if (errors < MAX_REPORTS)
                        $display("%0t: unexpected item, expected none, got note_out=%0d sounding=%0b",
                                 $time, m_data.note_out, m_data.sounding);
                    errors++;
                end else begin
                    want = notes_due_q.pop_front();
                    if (m_data.note_out !== want.note_out) begin
                        if (errors < MAX_REPORTS)
                            $display("%0t: note_out expected %0d got %0d",
                                     $time, want.note_out, m_data.note_out);
                        errors++;
                    end
                    if (m_data.sounding !== want.sounding) begin
                        if (errors < MAX_REPORTS)
                            $display("%0t: sounding expected %0b got %0b",
                                     $time, want.sounding, m_data.sounding);
                        errors++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                if (s_data.op == OP_TICK)
                    notes_due_q.push_back(predict_tick(s_data));
                else
                    slot_notes[s_data.slot] = s_data.note_value;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (psel && penable && pwrite && pready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

endmodule
